// ----- hw/rtl/rcs_pkg.sv -----
// Shared types and constants of the radio frame to servo pulse block.
// Beat payloads, register indexes, frame constants and the fixed pulse tables.
// No dependencies.
package rcs_pkg;

  // input beat kinds; the fourth code is dropped without a result
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_BATTERY = 2'd2;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_WING_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FS_START   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FS_END     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FS_MOTOR   = 2'd3;

  localparam logic [12:0] FS_START_RESET = 13'd1000;
  localparam logic [12:0] FS_END_RESET   = 13'd4000;
  localparam logic [15:0] FS_MOTOR_RESET = 16'd800;

  // frame layout
  localparam int         CAP_DEPTH  = 10;
  localparam logic [2:0] PIPE_CTRL  = 3'd1;
  localparam logic [7:0] HDR_0      = 8'd77;
  localparam logic [7:0] HDR_1      = 8'd86;
  localparam logic [7:0] HDR_2      = 8'd97;
  localparam logic [7:0] TRIM_KEY   = 8'd100;

  localparam logic [11:0] TRIM_RESET = 12'd700;
  localparam logic [11:0] SENS_RESET = 12'd300;

  localparam logic [15:0] PULSE_S1_RESET    = 16'd1800;
  localparam logic [15:0] PULSE_S2_RESET    = 16'd1500;
  localparam logic [15:0] PULSE_MOTOR_RESET = 16'd1000;
  localparam logic [15:0] PULSE_YAW_RESET   = 16'd1500;

  localparam logic [12:0] SILENCE_MAX = 13'd8191;

  // battery tenths = (sample * 9147) >> 18
  localparam logic [13:0] BATT_MULT  = 14'd9147;
  localparam int          BATT_SHIFT = 18;

  // floor(n / 254) = (n * 4227331) >> 30, exact for n below 2^22
  localparam int          MAP_DEN     = 254;
  localparam logic [22:0] RECIP_MULT  = 23'd4227331;
  localparam int          RECIP_SHIFT = 30;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [2:0]  pipe;
    logic [11:0] battery_sample;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        frame_valid;
    logic [7:0]  ack_byte;
    logic [15:0] pulse_ch1;
    logic [15:0] pulse_ch2;
    logic [15:0] pulse_ch3;
    logic [15:0] pulse_ch4;
    logic        failsafe_led;
  } out_item_t;

  typedef logic [15:0] pulse_lut_t [256];

  // byte to pulse map with a fixed span, truncated toward zero
  function automatic pulse_lut_t build_map_lut(int lo, int span);
    pulse_lut_t lut;
    for (int x = 0; x < 256; x++) begin
      lut[x] = 16'((x - 1) * span / MAP_DEN + lo);
    end
    return lut;
  endfunction

  localparam pulse_lut_t MOTOR_LUT = build_map_lut(800, 1400);
  localparam pulse_lut_t YAW_LUT   = build_map_lut(700, 1600);

endpackage

// ----- hw/rtl/rcs_if.sv -----
// Valid/ready stream interfaces for the input and result channels.
// Depends on rcs_pkg for the beat payload types.
interface rcs_in_if;
  logic               valid;
  logic               ready;
  rcs_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rcs_out_if;
  logic               valid;
  logic               ready;
  rcs_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/rc_frame_to_servo_pulses.sv -----
// Radio frame to servo pulse converter, top level.
// Depends on rcs_pkg and the stream interfaces in rcs_if.
//
// Usage: items carries payload bytes, millisecond ticks and battery samples,
// one beat each, selected by mode. Each final frame byte and each tick
// produce one beat on results; other beats produce none. The configuration
// port writes one register per cycle when cfg_wr_en is high; the user must
// write it only while idle, as the block itself does not enforce this. Each
// result passes the capture, product and quotient registers before it is
// loaded into the result register. One beat per cycle enters while the result
// register is free or being taken. The four-register pipeline: frame capture,
// span products, reciprocal quotient, then elevon mix and pulse store update.
// When the receiver stalls, the whole pipeline holds and items.ready drops
// only while a finished result waits; a new beat enters as soon as the
// result register is free or being taken.
// Reset: pipeline empties, configuration, trim, sensitivities and pulses
// return to their defaults; no clearing pass is needed.
module rc_frame_to_servo_pulses #(
  parameter int PAYLOAD_MAX = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  rcs_in_if.sink                             items,
  rcs_out_if.source                          results,
  input  logic                               cfg_wr_en,
  input  logic [rcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rcs_pkg::*;

  localparam int POS_W = $clog2(PAYLOAD_MAX + 1);

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic       frame_ok;
    logic [7:0] ack;
    logic       fs_on;
  } carry_t;

  typedef struct packed {
    carry_t      c;
    logic [7:0]  x3;
    logic [7:0]  x4;
    logic [7:0]  x5;
    logic [7:0]  x7;
    logic [11:0] trim;
    logic [11:0] s1;
    logic [11:0] s2;
  } stage_a_t;

  typedef struct packed {
    carry_t             c;
    logic               neg3;
    logic [20:0]        mag3;
    logic signed [15:0] lo3;
    logic               neg4;
    logic [20:0]        mag4;
    logic signed [15:0] lo4;
    logic signed [15:0] centre;
    logic [15:0]        motor;
    logic [15:0]        yaw;
  } stage_b_t;

  typedef struct packed {
    carry_t             c;
    logic [15:0]        map3;
    logic [15:0]        map4;
    logic signed [15:0] centre;
    logic [15:0]        motor;
    logic [15:0]        yaw;
  } stage_c_t;

  // configuration
  logic        wing_mode;
  logic [12:0] fs_start;
  logic [12:0] fs_end;
  logic [15:0] fs_motor;

  // block state
  logic [7:0]       cap [CAP_DEPTH];
  logic [7:0]       cap_next [CAP_DEPTH];
  logic [POS_W-1:0] pos;
  logic [11:0]      trim;
  logic [11:0]      sens1;
  logic [11:0]      sens2;
  logic [7:0]       batt;
  logic [12:0]      silence;
  logic             led;
  logic [15:0]      pulse_s1;
  logic [15:0]      pulse_s2;
  logic [15:0]      pulse_motor;
  logic [15:0]      pulse_yaw;

  stage_a_t sa, sa_next;
  stage_b_t sb, sb_next;
  stage_c_t sc, sc_next;

  logic advance;
  logic accept;
  logic is_byte;
  logic is_tick;
  logic is_batt;
  logic frame_end;
  logic hdr_ok;
  logic load_trim;
  logic [11:0] trim_new;
  logic [11:0] sens1_new;
  logic [11:0] sens2_new;
  logic [12:0] sil_inc;
  logic        fs_on;
  logic [POS_W-1:0] pos_inc;
  logic [25:0] batt_prod;

  assign advance = !results.valid || results.ready;
  assign items.ready = advance;
  assign accept  = items.valid && advance;
  assign is_byte = accept && (items.payload.mode == MODE_BYTE);
  assign is_tick = accept && (items.payload.mode == MODE_TICK);
  assign is_batt = accept && (items.payload.mode == MODE_BATTERY);
  assign frame_end = is_byte && items.payload.last_byte;

  // ---------------- capture stage ----------------
  always_comb begin
    for (int k = 0; k < CAP_DEPTH; k++) begin
      if (pos == POS_W'(k)) begin
        cap_next[k] = items.payload.data_byte;
      end else if (pos == '0) begin
        cap_next[k] = 8'd0;
      end else begin
        cap_next[k] = cap[k];
      end
    end
  end

  assign hdr_ok = (items.payload.pipe == PIPE_CTRL) && (cap_next[0] == HDR_0) &&
                  (cap_next[1] == HDR_1) && (cap_next[2] == HDR_2);
  assign load_trim = hdr_ok && (cap_next[6] == TRIM_KEY);
  assign trim_new  = load_trim ? 12'(cap_next[7]) * 12'd10 : trim;
  assign sens1_new = load_trim ? 12'(cap_next[8]) * 12'd10 : sens1;
  assign sens2_new = load_trim ? 12'(cap_next[9]) * 12'd10 : sens2;

  assign pos_inc = (pos < POS_W'(PAYLOAD_MAX)) ? POS_W'(pos + 1'b1) : pos;
  assign sil_inc = (silence == SILENCE_MAX) ? silence : 13'(silence + 1'b1);
  assign fs_on   = (sil_inc > fs_start) && (sil_inc < fs_end);
  assign batt_prod = 26'(items.payload.battery_sample) * 26'(BATT_MULT);

  always_comb begin
    sa_next.c.valid    = frame_end || is_tick;
    sa_next.c.kind     = is_tick ? KIND_TICK : KIND_FRAME;
    sa_next.c.frame_ok = frame_end && hdr_ok;
    sa_next.c.ack      = is_tick ? 8'd0 : batt;
    sa_next.c.fs_on    = fs_on;
    sa_next.x3   = cap_next[3];
    sa_next.x4   = cap_next[4];
    sa_next.x5   = cap_next[5];
    sa_next.x7   = cap_next[7];
    sa_next.trim = trim_new;
    sa_next.s1   = sens1_new;
    sa_next.s2   = sens2_new;
  end

  // ---------------- product stage ----------------
  logic signed [15:0] lo1, hi1, span1, lo2, hi2, span2, span4;
  logic signed [15:0] base, dlt, dlt_adj;
  logic signed [9:0]  xm3, xm4;
  logic signed [25:0] prod3, prod4;

  always_comb begin
    lo1   = 16'sd400 + $signed({4'd0, sa.trim}) + $signed({4'd0, sa.s1});
    hi1   = 16'sd2600 - $signed({4'd0, sa.s1});
    span1 = hi1 - lo1;
    lo2   = 16'sd480 + $signed({4'd0, sa.s2});
    hi2   = 16'sd2600 - $signed({4'd0, sa.s2});
    span2 = hi2 - lo2;
    span4 = wing_mode ? span1 : span2;
    xm3   = $signed({2'b00, sa.x3}) - 10'sd1;
    xm4   = $signed({2'b00, sa.x4}) - 10'sd1;
    prod3 = 26'(xm3) * 26'(span1);
    prod4 = 26'(xm4) * 26'(span4);
    // wing centre: halve toward zero
    base    = 16'sd400 + $signed({4'd0, sa.trim});
    dlt     = 16'sd2600 - base;
    dlt_adj = dlt + $signed({15'd0, dlt[15]});

    sb_next.c      = sa.c;
    sb_next.neg3   = prod3[25];
    sb_next.mag3   = 21'(prod3[25] ? -prod3 : prod3);
    sb_next.lo3    = lo1;
    sb_next.neg4   = prod4[25];
    sb_next.mag4   = 21'(prod4[25] ? -prod4 : prod4);
    sb_next.lo4    = wing_mode ? lo1 : lo2;
    sb_next.centre = base + (dlt_adj >>> 1);
    sb_next.motor  = MOTOR_LUT[sa.x5];
    sb_next.yaw    = YAW_LUT[sa.x7];
  end

  // ---------------- quotient stage ----------------
  logic [43:0]        recip3, recip4;
  logic [13:0]        qm3, qm4;
  logic signed [15:0] q3, q4;

  always_comb begin
    recip3 = 44'(sb.mag3) * 44'(RECIP_MULT);
    recip4 = 44'(sb.mag4) * 44'(RECIP_MULT);
    qm3    = recip3[RECIP_SHIFT +: 14];
    qm4    = recip4[RECIP_SHIFT +: 14];
    q3     = sb.neg3 ? -$signed({2'b00, qm3}) : $signed({2'b00, qm3});
    q4     = sb.neg4 ? -$signed({2'b00, qm4}) : $signed({2'b00, qm4});

    sc_next.c      = sb.c;
    sc_next.map3   = 16'(q3 + sb.lo3);
    sc_next.map4   = 16'(q4 + sb.lo4);
    sc_next.centre = sb.centre;
    sc_next.motor  = sb.motor;
    sc_next.yaw    = sb.yaw;
  end

  // ---------------- mix stage ----------------
  logic signed [16:0] roll_s, win_lo, win_hi;
  logic               roll_centred;
  logic [15:0]        elevon_l, elevon_r;
  logic [15:0]        s1_next, s2_next, motor_next, yaw_next;
  logic               led_next;

  always_comb begin
    roll_s = $signed({1'b0, sc.map4});
    win_lo = 17'(sc.centre) - 17'sd100;
    win_hi = 17'(sc.centre) + 17'sd100;
    roll_centred = (win_lo < roll_s) && (roll_s < win_hi);
    elevon_l = roll_centred ? 16'(16'd3000 - sc.map3) : 16'(sc.map4 - 16'd1600);
    elevon_r = roll_centred ? sc.map3 : sc.map4;

    s1_next    = pulse_s1;
    s2_next    = pulse_s2;
    motor_next = pulse_motor;
    yaw_next   = pulse_yaw;
    led_next   = led;
    if (sc.c.valid && sc.c.frame_ok) begin
      if (wing_mode) begin
        s1_next = elevon_l;
        s2_next = elevon_r;
      end else begin
        s1_next  = sc.map3;
        s2_next  = sc.map4;
        yaw_next = sc.yaw;
      end
      motor_next = sc.motor;
    end
    if (sc.c.valid && (sc.c.kind == KIND_TICK)) begin
      led_next = sc.c.fs_on;
      if (sc.c.fs_on) begin
        motor_next = fs_motor;
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      wing_mode <= 1'b0;
      fs_start  <= FS_START_RESET;
      fs_end    <= FS_END_RESET;
      fs_motor  <= FS_MOTOR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WING_MODE: wing_mode <= cfg_data[0];
        REG_FS_START:  fs_start  <= cfg_data[12:0];
        REG_FS_END:    fs_end    <= cfg_data[12:0];
        REG_FS_MOTOR:  fs_motor  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      trim    <= TRIM_RESET;
      sens1   <= SENS_RESET;
      sens2   <= SENS_RESET;
      batt    <= 8'd0;
      silence <= 13'd0;
    end else begin
      if (is_byte) begin
        cap <= cap_next;
        pos <= items.payload.last_byte ? '0 : pos_inc;
      end
      if (frame_end) begin
        silence <= 13'd0;
        trim    <= trim_new;
        sens1   <= sens1_new;
        sens2   <= sens2_new;
      end
      if (is_tick) begin
        silence <= sil_inc;
      end
      if (is_batt) begin
        batt <= batt_prod[BATT_SHIFT +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.c.valid    <= 1'b0;
      sb.c.valid    <= 1'b0;
      sc.c.valid    <= 1'b0;
      results.valid <= 1'b0;
      pulse_s1      <= PULSE_S1_RESET;
      pulse_s2      <= PULSE_S2_RESET;
      pulse_motor   <= PULSE_MOTOR_RESET;
      pulse_yaw     <= PULSE_YAW_RESET;
      led           <= 1'b0;
    end else if (advance) begin
      // hold everything while a finished result waits
      sa <= sa_next;
      sb <= sb_next;
      sc <= sc_next;
      pulse_s1    <= s1_next;
      pulse_s2    <= s2_next;
      pulse_motor <= motor_next;
      pulse_yaw   <= yaw_next;
      led         <= led_next;
      results.valid                <= sc.c.valid;
      results.payload.result_kind  <= sc.c.kind;
      results.payload.frame_valid  <= sc.c.frame_ok;
      results.payload.ack_byte     <= sc.c.ack;
      results.payload.pulse_ch1    <= s1_next;
      results.payload.pulse_ch2    <= s2_next;
      results.payload.pulse_ch3    <= motor_next;
      results.payload.pulse_ch4    <= yaw_next;
      results.payload.failsafe_led <= led_next;
    end
  end

endmodule

// ----- hw/rtl/rcs_checker.sv -----
// Port-level checks for the radio frame to servo pulse block, with its bind.
// Depends on rcs_pkg and on the top level rc_frame_to_servo_pulses.
module rcs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input rcs_pkg::out_item_t out_payload
);
  import rcs_pkg::*;

  logic tick_beat;
  assign tick_beat = in_valid && in_ready && (in_mode == MODE_TICK);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result beat changed while stalled");

  // tick results carry no frame status and no ack
  a_tick_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_payload.result_kind == KIND_TICK) |->
      !out_payload.frame_valid && (out_payload.ack_byte == 8'd0))
    else $error("tick result with frame fields set");

  // with the receiver ready meanwhile, a tick result shows once its beat has passed the pipeline registers
  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    tick_beat ##1 out_ready ##1 out_ready ##1 out_ready |=>
      out_valid && (out_payload.result_kind == KIND_TICK))
    else $error("tick result missing at expected latency");

endmodule

bind rc_frame_to_servo_pulses rcs_checker u_rcs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .in_mode     (items.payload.mode),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_payload (results.payload)
);

// ----- test/servo_pulse_check.sv -----
// Watches the item, result and configuration ports of the frame to servo pulse block,
// predicts every result beat from its own copy of the block state and compares them.
// Depends on rcs_pkg and the stream interfaces in rcs_if.
module servo_pulse_check #(
  parameter int PAYLOAD_MAX = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  rcs_in_if                               items,
  rcs_out_if                              results,
  input  logic                            cfg_wr_en,
  input  logic [rcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcs_pkg::*;

  localparam int          KEPT_BYTES  = 10;
  localparam logic [7:0]  HEADER_A    = 8'd77;
  localparam logic [7:0]  HEADER_B    = 8'd86;
  localparam logic [7:0]  HEADER_C    = 8'd97;
  localparam logic [7:0]  TRIM_MARK   = 8'd100;
  localparam logic [2:0]  CTRL_PIPE   = 3'd1;
  localparam logic [12:0] QUIET_LIMIT = 13'd8191;
  localparam longint      BYTE_SPAN   = 254;

  // configuration copy
  logic        cfg_wing;
  logic [12:0] cfg_fs_start;
  logic [12:0] cfg_fs_stop;
  logic [15:0] cfg_fs_motor;

  // block state copy
  logic [7:0]  frame_buf [KEPT_BYTES];
  int          frame_pos;
  int          trim_us;
  int          sens_pitch;
  int          sens_roll;
  logic [15:0] pulse_us [4];
  logic [7:0]  batt_tenths;
  logic [12:0] quiet_ms;
  logic        led_on;

  out_item_t   pulse_reports_q [$];

  // byte 1..255 onto lo..hi, signed, quotient truncated toward zero, low 16 bits kept
  function automatic logic [15:0] span_map(longint x, longint lo, longint hi);
    longint v;
    v = (x - 1) * (hi - lo) / BYTE_SPAN + lo;
    return v[15:0];
  endfunction

  function automatic void apply_control_frame();
    logic [15:0] lo, hi, pitch, roll, motor;
    int base, centre, roll_i;
    if (frame_buf[6] == TRIM_MARK) begin
      trim_us    = int'(frame_buf[7]) * 10;
      sens_pitch = int'(frame_buf[8]) * 10;
      sens_roll  = int'(frame_buf[9]) * 10;
    end
    motor = span_map(frame_buf[5], 800, 2200);
    if (cfg_wing) begin
      lo     = 16'(400 + trim_us + sens_pitch);
      hi     = 16'(2600 - sens_pitch);
      pitch  = span_map(frame_buf[3], lo, hi);
      roll   = span_map(frame_buf[4], lo, hi);
      base   = 400 + trim_us;
      centre = base + (2600 - base) / 2;
      roll_i = roll;
      // roll near centre: pitch drives both elevons in opposition
      if ((centre - 100 < roll_i) && (roll_i < centre + 100)) begin
        pulse_us[0] = 16'(32'd3000 - pitch);
        pulse_us[1] = pitch;
      end else begin
        pulse_us[0] = roll - 16'd1600;
        pulse_us[1] = roll;
      end
    end else begin
      pulse_us[0] = span_map(frame_buf[3], 400 + sens_pitch + trim_us, 2600 - sens_pitch);
      pulse_us[1] = span_map(frame_buf[4], 480 + sens_roll, 2600 - sens_roll);
      pulse_us[3] = span_map(frame_buf[7], 700, 2300);
    end
    pulse_us[2] = motor;
  endfunction

  function automatic out_item_t make_report(logic kind, logic ok, logic [7:0] ack);
    out_item_t r;
    r.result_kind  = kind;
    r.frame_valid  = ok;
    r.ack_byte     = ack;
    r.pulse_ch1    = pulse_us[0];
    r.pulse_ch2    = pulse_us[1];
    r.pulse_ch3    = pulse_us[2];
    r.pulse_ch4    = pulse_us[3];
    r.failsafe_led = led_on;
    return r;
  endfunction

  function automatic void predict_beat(in_item_t it);
    logic ok;
    case (it.mode)
      MODE_BYTE: begin
        if (frame_pos == 0) frame_buf = '{default: '0};
        if (frame_pos < KEPT_BYTES) frame_buf[frame_pos] = it.data_byte;
        if (frame_pos < PAYLOAD_MAX) frame_pos++;
        if (it.last_byte) begin
          frame_pos = 0;
          quiet_ms  = '0;
          ok = (it.pipe == CTRL_PIPE) && (frame_buf[0] == HEADER_A) &&
               (frame_buf[1] == HEADER_B) && (frame_buf[2] == HEADER_C);
          if (ok) apply_control_frame();
          pulse_reports_q.push_back(make_report(KIND_FRAME, ok, batt_tenths));
        end
      end
      MODE_TICK: begin
        if (quiet_ms < QUIET_LIMIT) quiet_ms++;
        if (quiet_ms > cfg_fs_start && quiet_ms < cfg_fs_stop) begin
          pulse_us[2] = cfg_fs_motor;
          led_on      = 1'b1;
        end else begin
          led_on = 1'b0;
        end
        pulse_reports_q.push_back(make_report(KIND_TICK, 1'b0, 8'd0));
      end
      MODE_BATTERY: batt_tenths = 8'((32'(it.battery_sample) * 32'd9147) >> 18);
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_report(out_item_t got);
    out_item_t want;
    if (pulse_reports_q.size() == 0) begin
      $error("result beat arrived with nothing expected");
      fail_count++;
      return;
    end
    want = pulse_reports_q.pop_front();
    check_field("result_kind", want.result_kind, got.result_kind);
    check_field("frame_valid", want.frame_valid, got.frame_valid);
    check_field("ack_byte", want.ack_byte, got.ack_byte);
    check_field("pulse_ch1", want.pulse_ch1, got.pulse_ch1);
    check_field("pulse_ch2", want.pulse_ch2, got.pulse_ch2);
    check_field("pulse_ch3", want.pulse_ch3, got.pulse_ch3);
    check_field("pulse_ch4", want.pulse_ch4, got.pulse_ch4);
    check_field("failsafe_led", want.failsafe_led, got.failsafe_led);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_wing     = 1'b0;
      cfg_fs_start = 13'd1000;
      cfg_fs_stop  = 13'd4000;
      cfg_fs_motor = 16'd800;
      frame_buf    = '{default: '0};
      frame_pos    = 0;
      trim_us      = 700;
      sens_pitch   = 300;
      sens_roll    = 300;
      pulse_us     = '{16'd1800, 16'd1500, 16'd1000, 16'd1500};
      batt_tenths  = '0;
      quiet_ms     = '0;
      led_on       = 1'b0;
      fail_count   = 0;
      pulse_reports_q.delete();
      reports_pending <= 0;
    end else begin
      if (results.valid && results.ready) check_report(results.payload);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WING_MODE: cfg_wing     = cfg_data[0];
          REG_FS_START:  cfg_fs_start = cfg_data[12:0];
          REG_FS_END:    cfg_fs_stop  = cfg_data[12:0];
          REG_FS_MOTOR:  cfg_fs_motor = cfg_data;
          default: ;
        endcase
      end
      if (items.valid && items.ready) predict_beat(items.payload);
      reports_pending <= pulse_reports_q.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top of the frame to servo pulse test: clock, reset, configuration writes and beat stimulus
// with sender idling and receiver stalls. Depends on rcs_pkg, rcs_if and servo_pulse_check.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rcs_pkg::*;

  localparam int         PAYLOAD_MAX   = 32;
  localparam int         RUN_LIMIT     = 500000;
  localparam int         SETTLE_CYCLES = 10;
  localparam int         LONG_HOLD     = 400;
  localparam int         PHASE_ITEMS   = 400;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam logic [2:0] CTRL_PIPE     = 3'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int reports_pending;
  int cycle_count = 0;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  rcs_in_if  items_if ();
  rcs_out_if results_if ();

  rc_frame_to_servo_pulses #(.PAYLOAD_MAX(PAYLOAD_MAX)) dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_if),
    .results   (results_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  servo_pulse_check #(.PAYLOAD_MAX(PAYLOAD_MAX)) pulse_check (
    .clk             (clk),
    .rst             (rst),
    .items           (items_if),
    .results         (results_if),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .reports_pending (reports_pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      results_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      results_if.ready <= 1'b0;
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      results_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic in_item_t make_item(logic [1:0] mode, logic [7:0] b, logic last,
                                         logic [2:0] pipe);
    in_item_t it;
    it.mode           = mode;
    it.data_byte      = b;
    it.last_byte      = last;
    it.pipe           = pipe;
    it.battery_sample = 12'($urandom);
    return it;
  endfunction

  task automatic put_item(in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid   <= 1'b1;
    items_if.payload <= it;
    do @(posedge clk); while (!items_if.ready);
    if (it.mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic put_ticks(int n);
    repeat (n) put_item(make_item(MODE_TICK, 8'($urandom), 1'($urandom), 3'($urandom)));
  endtask

  task automatic put_battery(logic [11:0] sample);
    in_item_t it;
    it = make_item(MODE_BATTERY, 8'($urandom), 1'($urandom), 3'($urandom));
    it.battery_sample = sample;
    put_item(it);
  endtask

  task automatic put_frame(logic [7:0] bytes [$], logic [2:0] pipe);
    for (int i = 0; i < bytes.size(); i++) begin
      if (i == bytes.size() - 1) put_item(make_item(MODE_BYTE, bytes[i], 1'b1, pipe));
      else put_item(make_item(MODE_BYTE, bytes[i], 1'b0, 3'($urandom)));
    end
  endtask

  task automatic random_frame();
    logic [7:0] bytes [$];
    logic [2:0] pipe;
    int len, r;
    r = $urandom_range(99);
    if (r < 8) len = $urandom_range(1, 9);
    else if (r < 18) len = $urandom_range(11, 40);
    else len = 10;
    repeat (len) bytes.push_back(8'($urandom));
    if (len >= 3 && $urandom_range(9) != 0) begin
      bytes[0] = 8'd77;
      bytes[1] = 8'd86;
      bytes[2] = 8'd97;
      // break the header now and then
      if ($urandom_range(14) == 0) bytes[$urandom_range(2)] ^= 8'(1 << $urandom_range(7));
    end
    if (len >= 7 && $urandom_range(2) == 0) bytes[6] = 8'd100;
    pipe = ($urandom_range(9) != 0) ? CTRL_PIPE : 3'($urandom);
    put_frame(bytes, pipe);
  endtask

  task automatic random_items(int n);
    int target, r;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 55) random_frame();
      else if (r < 85) put_ticks($urandom_range(1, 20));
      else if (r < 95) put_battery(12'($urandom));
      else put_item(make_item(MODE_UNUSED, 8'($urandom), 1'($urandom), 3'($urandom)));
    end
  endtask

  // drop valid and wait until every expected result is out and the pipeline is empty
  task automatic drain();
    items_if.valid <= 1'b0;
    do @(posedge clk); while (reports_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic wing, logic [12:0] fs_start, logic [12:0] fs_stop,
                              logic [15:0] fs_motor);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_WING_MODE;
    cfg_data  <= CFG_DATA_W'(wing);
    @(posedge clk);
    cfg_index <= REG_FS_START;
    cfg_data  <= CFG_DATA_W'(fs_start);
    @(posedge clk);
    cfg_index <= REG_FS_END;
    cfg_data  <= CFG_DATA_W'(fs_stop);
    @(posedge clk);
    cfg_index <= REG_FS_MOTOR;
    cfg_data  <= fs_motor;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, logic wing, logic [12:0] fs_start,
                           logic [12:0] fs_stop, logic [15:0] fs_motor, int n);
    drain();
    write_config(wing, fs_start, fs_stop, fs_motor);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    random_items(n);
  endtask

  initial begin
    int start;
    items_if.valid   = 1'b0;
    items_if.payload = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, bad frames, ignored code, failsafe edges
    write_config(1'b0, 13'd0, 13'd3, 16'hFFFF);
    put_battery(12'hFFF);
    put_frame('{8'd77, 8'd86, 8'd97, 8'd255, 8'd1, 8'd255, 8'd100, 8'd255, 8'd255, 8'd255},
              CTRL_PIPE);
    put_frame('{8'd77, 8'd86, 8'd98, 8'd0}, CTRL_PIPE);
    put_frame('{8'd77, 8'd86, 8'd97}, 3'd7);
    put_frame('{8'd0}, CTRL_PIPE);
    put_frame('{8'd77, 8'd86, 8'd97}, CTRL_PIPE);
    put_item(make_item(MODE_UNUSED, 8'hFF, 1'b1, 3'd7));
    put_ticks(3);
    put_battery(12'h000);

    run_phase(0, 0, 1'b1, 13'd2, 13'd12, 16'hFFFF, PHASE_ITEMS);
    run_phase(78, 0, 1'b0, 13'd0, 13'd8191, 16'h0000, PHASE_ITEMS);
    run_phase(0, 78, 1'b1, 13'd8191, 13'd0, 16'($urandom), PHASE_ITEMS);
    start = $urandom_range(1, 15);
    run_phase(36, 36, 1'b0, 13'(start), 13'(start + $urandom_range(1, 20)), 16'($urandom),
              PHASE_ITEMS);

    // receiver holds off while ticks keep coming, so the block backs up
    run_phase(0, 0, 1'b1, 13'd4, 13'd40, 16'($urandom), 0);
    long_hold_req <= 1'b1;
    put_ticks(60);
    random_items(PHASE_ITEMS);

    // silence count saturates at its top; the window closes just below it
    run_phase(0, 0, 1'b1, 13'd8189, 13'd8191, 16'hA5A5, 0);
    put_ticks(8200);
    drain();

    if (fail_count == 0 && reports_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
